// ----- sv/mmh2_pkg.sv -----
// Shared types and constants for the streaming MurmurHash2 block.
`default_nettype none

package mmh2_pkg;

  localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
  localparam int          MIX_SHIFT = 24;
  localparam logic [31:0] SEED      = 32'd97;
  localparam int          FIN_SH1   = 13;
  localparam int          FIN_SH2   = 15;
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX1,
    S_MIX2,
    S_FIN
  } mmh2_state_t;

  // Commands from the controller to the datapath, at most one high per cycle.
  typedef struct packed {
    logic load;
    logic mix1;
    logic mix2;
    logic fin;
  } mmh2_cmd_t;

  typedef struct packed {
    logic full_word;
  } mmh2_status_t;

endpackage

`default_nettype wire

// ----- sv/mmh2_datapath.sv -----
// Hash datapath: running hash, key and product registers around one shared multiplier.
`default_nettype none

module mmh2_datapath
  import mmh2_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [31:0]  key_word,
  input  wire logic [2:0]   valid_bytes,
  input  wire logic [30:0]  key_length,
  input  wire logic         first_item,
  input  wire mmh2_cmd_t    cmd,
  output mmh2_status_t      st,
  output logic [31:0]       hash_value
);

  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] prod;
  logic [31:0] h_init;
  logic [31:0] tail_bits;
  logic [31:0] mul_a;
  logic [31:0] product;
  logic [31:0] fin_value;
  logic        full_word;

  assign full_word    = (valid_bytes >= FULL_BYTES);
  assign st.full_word = full_word;

  assign h_init = first_item ? (SEED ^ {1'b0, key_length}) : h;

  always_comb begin
    case (valid_bytes)
      3'd1:    tail_bits = key_word & 32'h000000ff;
      3'd2:    tail_bits = key_word & 32'h0000ffff;
      3'd3:    tail_bits = key_word & 32'h00ffffff;
      default: tail_bits = '0;
    endcase
  end

  // Operand selection for the single multiplier by the fixed mixing constant.
  always_comb begin
    if (cmd.load) begin
      mul_a = full_word ? key_word : (h_init ^ tail_bits);
    end else if (cmd.mix1) begin
      mul_a = h;
    end else if (cmd.mix2) begin
      mul_a = k;
    end else begin
      mul_a = h ^ (h >> FIN_SH1);
    end
  end

  assign product   = mul_a * MIX_MUL;
  assign fin_value = product ^ (product >> FIN_SH2);

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0;
    end else if (cmd.load) begin
      if (full_word) begin
        h    <= h_init;
        prod <= product;
      end else if (valid_bytes != 3'd0) begin
        h <= product;
      end else begin
        h <= h_init;
      end
    end else if (cmd.mix1) begin
      // prod holds the key times the constant; h times the constant replaces it.
      k    <= prod ^ (prod >> MIX_SHIFT);
      prod <= product;
    end else if (cmd.mix2) begin
      h <= prod ^ product;
    end else if (cmd.fin) begin
      h          <= fin_value;
      hash_value <= fin_value;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mmh2_ctrl.sv -----
// Sequencing controller for the MurmurHash2 block and its output handshake.
`default_nettype none

module mmh2_ctrl
  import mmh2_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          last_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire mmh2_status_t  st,
  output mmh2_cmd_t          cmd
);

  mmh2_state_t state;
  mmh2_state_t state_next;
  logic        last_pend;
  logic        accept;
  logic        out_busy;

  assign accept   = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (st.full_word) begin
            state_next = S_MIX1;
          end else if (last_item) begin
            state_next = S_FIN;
          end
        end
      end
      S_MIX1: state_next = S_MIX2;
      S_MIX2: state_next = last_pend ? S_FIN : S_IDLE;
      S_FIN: begin
        if (!out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_MIX1:  cmd.mix1 = 1'b1;
      S_MIX2:  cmd.mix2 = 1'b1;
      S_FIN:   cmd.fin  = !out_busy;
      default: cmd      = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_pend <= last_item;
      end
      // A finished hash may only be loaded once the previous beat has left.
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_fin_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !(out_valid && out_stall))
    else $error("finish overwrote a pending result");

  a_full_word_mixes: assert property (@(posedge clk) disable iff (rst)
    (accept && st.full_word) |=> (state == S_MIX1))
    else $error("full word did not enter block mix");

  a_mix_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX1) |=> (state == S_MIX2))
    else $error("block mix steps out of order");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside finish step");

endmodule

`default_nettype wire

// ----- sv/murmur2_hash_stream.sv -----
// Top level of the streaming 32-bit MurmurHash2 block with seed 97.
`default_nettype none

// Streaming MurmurHash2 (seed 97 XOR key length): the key arrives as
// little-endian words, first byte in bits 7:0, and one hash beat leaves
// after the item marked last. A word with four or more valid bytes takes
// the load, first mix and second mix steps, as its three dependent
// multiplications by the mixing constant share one 32-bit multiplier; a
// tail word of 0 to 3 bytes needs only the load step. The last item adds
// a final avalanche mix on that multiplier, which waits while an earlier
// hash beat is held in the output register. Input stalls while mixing.
module murmur2_hash_stream
  import mmh2_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [31:0]  key_word,
  input  wire logic [2:0]   valid_bytes,
  input  wire logic [30:0]  key_length,
  input  wire logic         first_item,
  input  wire logic         last_item,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [31:0]       hash_value
);

  mmh2_cmd_t    cmd;
  mmh2_status_t st;

  mmh2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_item (last_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  mmh2_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .key_word    (key_word),
    .valid_bytes (valid_bytes),
    .key_length  (key_length),
    .first_item  (first_item),
    .cmd         (cmd),
    .st          (st),
    .hash_value  (hash_value)
  );

endmodule

`default_nettype wire

// ----- dv/murmur2_hash_stream_tb.sv -----
// Self-checking testbench for the streaming MurmurHash2 block.
`default_nettype none

module murmur2_hash_stream_tb
  import mmh2_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_ITEMS    = 1550;
  localparam int DRAIN_CYCLES    = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] key_word = '0;
  logic [2:0]  valid_bytes = '0;
  logic [30:0] key_length = '0;
  logic        first_item = 1'b0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] hash_value;

  logic [31:0] hash_state = '0;
  logic [31:0] expected_hashes[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_off_req = 1'b0;
  int          hold_off_left = 0;

  murmur2_hash_stream dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .key_word(key_word),
    .valid_bytes(valid_bytes),
    .key_length(key_length),
    .first_item(first_item),
    .last_item(last_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hash_value(hash_value)
  );

  always #5 clk = ~clk;

  // Advances the running hash by one accepted word and queues the finished
  // hash when the word closes a key.
  function automatic void advance_hash(logic [31:0] word, logic [2:0] count,
                                       logic [30:0] len, logic first, logic last);
    logic [31:0] h;
    logic [31:0] k;
    h = first ? (SEED ^ {1'b0, len}) : hash_state;
    if (count >= FULL_BYTES) begin
      k = word * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      h = (h * MIX_MUL) ^ k;
    end else begin
      if (count >= 3'd3) h = h ^ (word & 32'h00ff_0000);
      if (count >= 3'd2) h = h ^ (word & 32'h0000_ff00);
      if (count >= 3'd1) begin
        h = h ^ (word & 32'h0000_00ff);
        h = h * MIX_MUL;
      end
    end
    if (last) begin
      h = h ^ (h >> FIN_SH1);
      h = h * MIX_MUL;
      h = h ^ (h >> FIN_SH2);
      expected_hashes.push_back(h);
    end
    hash_state = h;
  endfunction

  task automatic send_item(logic [31:0] word, logic [2:0] count, logic [30:0] len,
                           logic first, logic last);
    int gap;
    if (tx_idle_on && $urandom_range(99) < 35) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    key_word    <= word;
    valid_bytes <= count;
    key_length  <= len;
    first_item  <= first;
    last_item   <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    advance_hash(word, count, len, first, last);
    items_sent++;
  endtask

  // A mostly well-formed key of nbytes random bytes. A key whose length
  // is a multiple of four sometimes closes with an empty word instead.
  task automatic send_key(int unsigned nbytes);
    int unsigned nwords;
    int unsigned rem;
    logic [30:0] len;
    logic [2:0]  count;
    bit          pad;
    nwords = nbytes / 4;
    rem    = nbytes % 4;
    len    = ($urandom_range(19) == 0) ? 31'($urandom) : 31'(nbytes);
    pad    = (rem == 0) && ((nwords == 0) || ($urandom_range(1) == 1));
    for (int i = 0; i < nwords; i++) begin
      count = ($urandom_range(7) == 0) ? 3'($urandom_range(5, 7)) : FULL_BYTES;
      send_item($urandom, count, len, i == 0, (i == nwords - 1) && (rem == 0) && !pad);
    end
    if (rem != 0 || pad) send_item($urandom, 3'(rem), len, nwords == 0, 1'b1);
  endtask

  task automatic test_directed();
    // Straight after reset the running hash is zero and a word without a
    // first mark carries on from it.
    send_item(32'h1234_5678, FULL_BYTES, 31'd0, 1'b0, 1'b0);
    send_item(32'h00ab_cdef, 3'd3, 31'd0, 1'b0, 1'b1);
    // Empty key; the unused bytes are garbage and must be ignored.
    send_item(32'hffff_ffff, 3'd0, 31'd0, 1'b1, 1'b1);
    // Largest length, extreme words and the oversized byte counts.
    send_item(32'hffff_ffff, FULL_BYTES, 31'h7fff_ffff, 1'b1, 1'b0);
    send_item(32'h0000_0000, 3'd5, 31'h7fff_ffff, 1'b0, 1'b0);
    send_item(32'hffff_ffff, 3'd6, 31'h7fff_ffff, 1'b0, 1'b0);
    send_item(32'h0000_0000, 3'd7, 31'h7fff_ffff, 1'b0, 1'b1);
    for (int c = 1; c < 4; c++) begin
      send_item(32'hffff_ffff, 3'(c), 31'(c), 1'b1, 1'b1);
      send_item(32'ha5a5_a5a5, 3'(c), 31'(c), 1'b1, 1'b1);
    end
    // A short word in the middle of a key.
    send_item(32'h0102_0304, FULL_BYTES, 31'd11, 1'b1, 1'b0);
    send_item(32'hdead_beef, 3'd2, 31'd11, 1'b0, 1'b0);
    send_item(32'h5a5a_5a5a, FULL_BYTES, 31'd11, 1'b0, 1'b0);
    send_item(32'hffff_ff7e, 3'd1, 31'd11, 1'b0, 1'b1);
    send_item(32'h0000_0000, FULL_BYTES, 31'd4, 1'b1, 1'b1);
    // Carrying on from an emitted hash, a restart mid-key and a length that
    // does not match the bytes sent.
    send_item(32'h8000_0001, FULL_BYTES, 31'd0, 1'b0, 1'b1);
    send_item(32'hcafe_f00d, FULL_BYTES, 31'd3, 1'b1, 1'b0);
    send_item(32'h1357_9bdf, FULL_BYTES, 31'd1000, 1'b1, 1'b0);
    send_item(32'h2468_ace0, 3'd0, 31'd0, 1'b0, 1'b1);
  endtask

  task automatic test_random_keys();
    while (items_sent < RANDOM_ITEMS) begin
      // A long stretch with neither side idling.
      tx_idle_on = !(items_sent >= 600 && items_sent < 900);
      rx_idle_on = tx_idle_on;
      if ($urandom_range(9) == 0) begin
        send_item($urandom, 3'($urandom_range(7)), 31'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if ($urandom_range(9) == 0) begin
        send_key($urandom_range(200));
      end else begin
        send_key($urandom_range(24));
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // The receiver holds off while keys keep coming, so the block backs up
  // and stalls its input.
  task automatic test_backpressure();
    tx_idle_on   = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) send_key($urandom_range(12));
    tx_idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_off_req) begin
      hold_off_left = HOLD_OFF_CYCLES;
      hold_off_req  = 1'b0;
    end
    if (hold_off_left != 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= rx_idle_on && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected hash beat %h", hash_value);
      end else begin
        want = expected_hashes.pop_front();
        if (hash_value !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("hash mismatch: expected %h, got %h", want, hash_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("murmur2_hash_stream verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_keys();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("murmur2_hash_stream verification clean");
    end else begin
      $display("murmur2_hash_stream verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- murmur2_hash_stream.f -----
sv/mmh2_pkg.sv
sv/mmh2_datapath.sv
sv/mmh2_ctrl.sv
sv/murmur2_hash_stream.sv
dv/murmur2_hash_stream_tb.sv
